/* hw/rtl/bed_pkg.sv */
// Package: shared types and constants for the backslash escape decoder.
`default_nettype none
package bed_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_SEP  = 2'd1,
    CMD_END  = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_t;

  // Decoder mode
  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_BSLASH = 2'd1,
    MODE_OCTAL  = 2'd2
  } mode_t;

  // Character constants
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LC     = 8'h63;
  localparam logic [7:0] CH_LF_ESC = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;

  // Queue depth between front and back
  localparam int unsigned QDEPTH = 2;

  // One decoded request: one or two output bytes
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } entry_t;

endpackage
`default_nettype wire

/* hw/rtl/backslash_escape_decoder.sv */
// Top level: backslash escape decoder, front end, entry queue and back end.
//
// Input channel (in_valid/in_ready): one request per accepted cycle, carrying
// in_command (data byte, argument separator, end of input) and in_data_byte.
// Output channel (out_valid/out_ready): one decoded byte per cycle while out_ready is high, with
// out_last_of_run marking the final byte caused by one input request.
// A request yields zero, one or two bytes.
// The front end decodes a request in the cycle it is accepted and pushes an
// entry into a two-deep queue; the back end pops it and drives the output
// register. Throughput: one input request per cycle while outputs drain;
// the output port moves one byte per cycle while out_ready is high, so
// two-byte requests are limited by the single-byte output register.
// When the receiver stalls, the queue fills and in_ready drops; nothing is
// lost. Synchronous active-low reset clears decoder state, queue pointers and output valid.
`default_nettype none
module backslash_escape_decoder
  import bed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_out_byte,
  output logic            out_last_of_run
);

  logic   q_full, q_push, q_pop, q_not_empty;
  entry_t q_entry, q_head;

  // Decode
  bed_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // Decouple
  bed_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Serialize
  bed_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

/* hw/rtl/bed_front.sv */
// Front end: accepts input requests, runs the escape state machine, emits entries.
`default_nettype none
module bed_front
  import bed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output entry_t          q_entry
);

  mode_t      mode_r, mode_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [8:0] oct_r, oct_nxt;
  logic       sup_r, sup_nxt;
  logic       accept;
  logic       is_digit;
  logic       fl_emit;
  logic [7:0] fl_byte;
  logic       emit;
  cmd_t       cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cmd      = cmd_t'(in_command);
  assign is_digit = (in_data_byte >= CH_ZERO) && (in_data_byte <= CH_SEVEN);

  // Pending escape flushed by separator or end
  assign fl_emit = (mode_r != MODE_PLAIN);
  assign fl_byte = (mode_r == MODE_BSLASH) ? CH_BSLASH : oct_r[7:0];

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      cnt_r  <= 2'd0;
      oct_r  <= 9'd0;
      sup_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      oct_r  <= oct_nxt;
      sup_r  <= sup_nxt;
    end
  end

  // Next state and produced entry
  always_comb begin
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    oct_nxt       = oct_r;
    sup_nxt       = sup_r;
    emit          = 1'b0;
    q_entry.two   = 1'b0;
    q_entry.byte0 = in_data_byte;
    q_entry.byte1 = in_data_byte;
    unique case (cmd)
      CMD_DATA: begin
        unique case (mode_r)
          MODE_OCTAL: begin
            if (cnt_r != 2'd3 && is_digit) begin
              oct_nxt = {oct_r[5:0], in_data_byte[2:0]};
              cnt_nxt = cnt_r + 2'd1;
            end else begin
              emit          = 1'b1;
              q_entry.two   = 1'b1;
              q_entry.byte0 = oct_r[7:0];
              mode_nxt      = MODE_PLAIN;
              cnt_nxt       = 2'd0;
              oct_nxt       = 9'd0;
            end
          end
          MODE_BSLASH: begin
            mode_nxt = MODE_PLAIN;
            emit     = 1'b1;
            unique case (in_data_byte)
              CH_BSLASH: q_entry.byte0 = CH_BSLASH;
              CH_LA:     q_entry.byte0 = CH_BEL;
              CH_LB:     q_entry.byte0 = CH_BS;
              CH_LF_ESC: q_entry.byte0 = CH_FF;
              CH_LN:     q_entry.byte0 = CH_LF;
              CH_LR:     q_entry.byte0 = CH_CR;
              CH_LT:     q_entry.byte0 = CH_TAB;
              CH_LV:     q_entry.byte0 = CH_VT;
              CH_LC: begin
                emit    = 1'b0;
                sup_nxt = 1'b1;
              end
              CH_ZERO: begin
                emit     = 1'b0;
                mode_nxt = MODE_OCTAL;
                cnt_nxt  = 2'd0;
                oct_nxt  = 9'd0;
              end
              default: begin
                // unknown escape: backslash then the byte itself
                q_entry.two   = 1'b1;
                q_entry.byte0 = CH_BSLASH;
              end
            endcase
          end
          default: begin
            if (in_data_byte == CH_BSLASH) begin
              mode_nxt = MODE_BSLASH;
            end else begin
              emit = 1'b1;
            end
          end
        endcase
      end
      CMD_SEP: begin
        emit          = 1'b1;
        q_entry.two   = fl_emit;
        q_entry.byte0 = fl_emit ? fl_byte : CH_SPACE;
        q_entry.byte1 = CH_SPACE;
        mode_nxt      = MODE_PLAIN;
        cnt_nxt       = 2'd0;
        oct_nxt       = 9'd0;
      end
      CMD_END: begin
        emit          = fl_emit || !sup_r;
        q_entry.two   = fl_emit && !sup_r;
        q_entry.byte0 = fl_emit ? fl_byte : CH_LF;
        q_entry.byte1 = CH_LF;
        mode_nxt      = MODE_PLAIN;
        cnt_nxt       = 2'd0;
        oct_nxt       = 9'd0;
        sup_nxt       = 1'b0;
      end
      default: begin
        // reserved command: no result, state held
      end
    endcase
  end

  assign q_push = accept && emit;

endmodule
`default_nettype wire

/* hw/rtl/bed_queue.sv */
// Queue: short FIFO of decoded entries between front and back.
`default_nettype none
module bed_queue
  import bed_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        not_empty,
  output entry_t      head
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  entry_t          mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bed_back.sv */
// Back end: serializes queued entries into single output bytes.
`default_nettype none
module bed_back
  import bed_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_not_empty,
  input  wire entry_t      q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_out_byte,
  output logic             out_last_of_run
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       pend_r;
  logic [7:0] pend_byte_r;
  logic       advance;

  assign advance = !valid_r || out_ready;
  assign q_pop   = advance && !pend_r && q_not_empty;

  // Control: output valid and pending second byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (advance) begin
      if (pend_r) begin
        valid_r <= 1'b1;
        pend_r  <= 1'b0;
      end else begin
        valid_r <= q_not_empty;
        pend_r  <= q_not_empty && q_head.two;
      end
    end
  end

  // Output and pending payload
  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_r) begin
        byte_r <= pend_byte_r;
        last_r <= 1'b1;
      end else begin
        byte_r      <= q_head.byte0;
        last_r      <= !q_head.two;
        pend_byte_r <= q_head.byte1;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_out_byte    = byte_r;
  assign out_last_of_run = last_r;

endmodule
`default_nettype wire
